// ===== hw/rtl/swk_pkg.sv =====
package swk_pkg;

    localparam int MODULE_COUNT = 4;
    localparam int MOD_W        = $clog2(MODULE_COUNT);
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int ATAN_LEN     = 24;
    localparam int ATAN_IDX_W   = 5;

    // CORDIC datapath: wheel vector is Q.20, up to ~2^31.1, gain ~1.65
    localparam int CW           = 36;
    localparam int ACC_W        = 32;

    // shared multiplier operand widths
    localparam int MA_W         = 18;
    localparam int MB_W         = 30;
    localparam int MP_W         = MA_W + MB_W;

    localparam logic [MB_W-1:0] INV_GAIN_Q30 = 30'd652032874;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 17;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx REG_HALF_WHEELBASE = 3'd0;
    localparam t_cfg_idx REG_HALF_TRACK     = 3'd1;
    localparam t_cfg_idx REG_INV_RADIUS     = 3'd2;
    localparam t_cfg_idx REG_STEER_MASK     = 3'd3;
    localparam t_cfg_idx REG_DRIVE_MASK     = 3'd4;
    localparam t_cfg_idx REG_STEER_LIMIT    = 3'd5;

    typedef struct packed {
        logic load;
        logic step;
    } t_cordic_ctl;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ACC_W-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
        logic [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/swk_if.sv =====
interface swk_in_if import swk_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;

    modport source(output valid, output vel_x, output vel_y, output yaw_rate, input ready);
    modport sink(input valid, input vel_x, input vel_y, input yaw_rate, output ready);
endinterface

interface swk_out_if import swk_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MOD_W-1:0]   module_res;
    logic signed [31:0] drive_rate;
    logic               drive_valid;
    logic               drive_held;
    logic signed [15:0] wheel_heading;
    logic               steer_valid;
    logic               last_of_run;

    modport source(output valid, output module_res, output drive_rate, output drive_valid,
                   output drive_held, output wheel_heading, output steer_valid,
                   output last_of_run, input ready);
    modport sink(input valid, input module_res, input drive_rate, input drive_valid,
                 input drive_held, input wheel_heading, input steer_valid,
                 input last_of_run, output ready);
endinterface

interface swk_cfg_if import swk_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/swerve_wheel_kinematics.sv =====
// Swerve drive inverse kinematics, four wheel modules.
// i_cmd: one beat per body velocity command (vel_x, vel_y, yaw_rate).
// o_res: four beats per command (modules 0..3), or eight when a steer jump
//   reaches steer_change_limit: four steer beats with drive held at zero,
//   then four drive beats. last_of_run marks the final beat of a command.
// i_cfg: register writes (index, data), always ready; write only while idle.
// One command at a time: i_cmd.ready is high only in the idle state.
// Sequence: yaw products (S_MULA, S_MULB, S_WB), then per module: load, 16
//   CORDIC steps, angle fixup, multiplier states S_M1..S_M5, saturate;
//   then S_EMIT loads the result beats into the output register,
//   one beat per cycle while the receiver takes them.
// The shared CORDIC unit and the single 18x30 multiplier serve each module in turn.
// A stalled receiver holds the output register; the block keeps the beat and
//   waits, and accepts the next command once the last beat is loaded.
// Reset (synchronous, active low) restores register defaults and clears the
//   stored steer angles to zero.
module swerve_wheel_kinematics import swk_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swk_in_if.sink    i_cmd,
    swk_out_if.source o_res,
    swk_cfg_if.sink   i_cfg
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_MULA  = 14'b00000000000010,
        S_MULB  = 14'b00000000000100,
        S_WB    = 14'b00000000001000,
        S_LOAD  = 14'b00000000010000,
        S_ROT   = 14'b00000000100000,
        S_ANGLE = 14'b00000001000000,
        S_M1    = 14'b00000010000000,
        S_M2    = 14'b00000100000000,
        S_M3    = 14'b00001000000000,
        S_M4    = 14'b00010000000000,
        S_M5    = 14'b00100000000000,
        S_SAT   = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } t_state;

    localparam int WW   = 34;  // yaw product width
    localparam int AW   = 18;  // angle fixup width
    localparam int RACC = 65;  // multiply accumulator

    t_state r_state;

    // configuration
    logic [15:0]                r_hw, r_ht, r_iwr;
    logic [MODULE_COUNT-1:0]    r_smask, r_dmask;
    logic [16:0]                r_limit;

    // command and per-module state
    logic signed [15:0]         r_vx, r_vy, r_wz;
    logic signed [WW-1:0]       r_wa, r_wb;
    logic [MOD_W-1:0]           r_mod;
    logic                       r_zero;
    logic [RACC-1:0]            r_acc;
    logic [MODULE_COUNT-1:0]    r_neg;
    logic signed [31:0]         r_drive [MODULE_COUNT];
    logic [15:0]                r_prev  [MODULE_COUNT];
    logic                       r_sf;
    logic [MOD_W:0]             r_beat;

    // output register
    logic                       r_out_valid;
    logic [MOD_W-1:0]           r_out_mod;
    logic signed [31:0]         r_out_drive;
    logic                       r_out_dvalid, r_out_held, r_out_svalid, r_out_last;
    logic signed [15:0]         r_out_steer;

    // shared units
    logic [MA_W-1:0]            mul_a;
    logic [MB_W-1:0]            mul_b;
    logic [MP_W-1:0]            mul_p;
    t_cordic_ctl                cor_ctl;
    logic signed [CW-1:0]       cor_x, cor_y, cor_xo;
    logic [ACC_W-1:0]           cor_acc;
    logic                       cor_done;

    swk_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    swk_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cor_ctl),
        .i_x     (cor_x),
        .i_y     (cor_y),
        .o_x     (cor_xo),
        .o_acc   (cor_acc),
        .o_done  (cor_done)
    );

    // |yaw_rate|, at most 32768
    logic [16:0]          wz_ext, wz_abs;
    logic                 cmd_take, out_take, last_beat;
    logic signed [CW-1:0] vx_s, vy_s, wa_s, wb_s;
    logic [33:0]          x_mag;
    logic [ACC_W-1:0]     ang_sum;
    logic signed [AW-1:0] a0, a1, a2, diff, diff_abs;
    logic                 flip;
    logic signed [WW-1:0] yaw_prod;
    logic [31:0]          sat_mag;

    always_comb begin
        wz_ext = {r_wz[15], r_wz};
        wz_abs = r_wz[15] ? 17'(-wz_ext) : wz_ext;
    end

    // wheel vector for the current module, Q.20
    always_comb begin
        vx_s  = CW'({{(CW-16){r_vx[15]}}, r_vx}) <<< 12;
        vy_s  = CW'({{(CW-16){r_vy[15]}}, r_vy}) <<< 12;
        wa_s  = {{(CW-WW){r_wa[WW-1]}}, r_wa};
        wb_s  = {{(CW-WW){r_wb[WW-1]}}, r_wb};
        // FL (+hw,+ht) FR (+hw,-ht) RL (-hw,+ht) RR (-hw,-ht)
        cor_x = r_mod[0] ? (vx_s + wb_s) : (vx_s - wb_s);
        cor_y = r_mod[1] ? (vy_s - wa_s) : (vy_s + wa_s);
    end

    assign cor_ctl.load = (r_state == S_LOAD);
    assign cor_ctl.step = (r_state == S_ROT);

    // final CORDIC x is non-negative; zero vector forces speed zero
    assign x_mag = r_zero ? '0 : cor_xo[33:0];

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MULA: begin
                mul_a = MA_W'(wz_abs);
                mul_b = MB_W'(r_hw);
            end
            S_MULB: begin
                mul_a = MA_W'(wz_abs);
                mul_b = MB_W'(r_ht);
            end
            S_ANGLE: begin
                mul_a = x_mag[17:0];
                mul_b = INV_GAIN_Q30;
            end
            S_M1: begin
                mul_a = MA_W'(x_mag[33:18]);
                mul_b = INV_GAIN_Q30;
            end
            S_M3: begin
                mul_a = r_acc[47:30];
                mul_b = MB_W'(r_iwr);
            end
            S_M4: begin
                mul_a = MA_W'(r_acc[62:48]);
                mul_b = MB_W'(r_iwr);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // signed yaw product from the unsigned one
    assign yaw_prod = r_wz[15] ? -WW'(mul_p[WW-1:0]) : WW'(mul_p[WW-1:0]);

    // angle fixup: round to 16 bits, steer sign, half-turn flip
    always_comb begin
        ang_sum = cor_acc + 32'h8000;
        a0      = r_zero ? '0 : AW'(signed'(ang_sum[31:16]));
        a1      = r_smask[r_mod] ? -a0 : a0;
        a2      = a1;
        flip    = 1'b0;
        if (a1 > AW'(16384) || a1 < -AW'(16384)) begin
            a2   = a1 - AW'(32768);
            if (a2 > AW'(32768)) begin
                a2 = a2 - AW'(65536);
            end
            if (a2 < -AW'(32768)) begin
                a2 = a2 + AW'(65536);
            end
            flip = 1'b1;
        end else if (a1 == -AW'(16384) && r_vx == 0 && r_wz == 0) begin
            // pure lateral command at minus a quarter turn
            a2   = AW'(16384);
            flip = 1'b1;
        end
        diff     = a2 - AW'(signed'(r_prev[r_mod]));
        diff_abs = diff[AW-1] ? -diff : diff;
    end

    // Q16.16 magnitude saturates at 2^31-1
    assign sat_mag = (|r_acc[RACC-1:43]) ? 32'h7FFF_FFFF : r_acc[43:12];

    assign cmd_take  = i_cmd.valid && i_cmd.ready;
    assign out_take  = !r_out_valid || o_res.ready;
    assign last_beat = r_sf ? (r_beat == (MOD_W+1)'(2*MODULE_COUNT-1))
                            : (r_beat == (MOD_W+1)'(MODULE_COUNT-1));

    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hw        <= 16'd11571;
            r_ht        <= 16'd4813;
            r_iwr       <= 16'd2510;
            r_smask     <= 4'd15;
            r_dmask     <= 4'd5;
            r_limit     <= 17'd65536;
            r_out_valid <= 1'b0;
            r_mod       <= '0;
            r_beat      <= '0;
            r_sf        <= 1'b0;
            for (int i = 0; i < MODULE_COUNT; i++) begin
                r_prev[i] <= '0;
            end
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_HALF_WHEELBASE: r_hw    <= i_cfg.data[15:0];
                    REG_HALF_TRACK:     r_ht    <= i_cfg.data[15:0];
                    REG_INV_RADIUS:     r_iwr   <= i_cfg.data[15:0];
                    REG_STEER_MASK:     r_smask <= i_cfg.data[MODULE_COUNT-1:0];
                    REG_DRIVE_MASK:     r_dmask <= i_cfg.data[MODULE_COUNT-1:0];
                    REG_STEER_LIMIT:    r_limit <= i_cfg.data;
                    default: ;
                endcase
            end

            // S_EMIT reloads the output register itself
            if (o_res.ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (cmd_take) begin
                        r_vx    <= i_cmd.vel_x;
                        r_vy    <= i_cmd.vel_y;
                        r_wz    <= i_cmd.yaw_rate;
                        r_mod   <= '0;
                        r_sf    <= 1'b0;
                        r_state <= S_MULA;
                    end
                end
                S_MULA: r_state <= S_MULB;
                S_MULB: begin
                    r_wa    <= yaw_prod;
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_wb    <= yaw_prod;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_zero  <= (cor_x == 0) && (cor_y == 0);
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (cor_done) begin
                        r_state <= S_ANGLE;
                    end
                end
                S_ANGLE: begin
                    r_prev[r_mod] <= a2[15:0];
                    r_neg[r_mod]  <= flip;
                    if (diff_abs >= signed'({1'b0, r_limit})) begin
                        r_sf <= 1'b1;
                    end
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_acc   <= RACC'(mul_p);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_acc   <= r_acc + (RACC'(mul_p) << 18) + (RACC'(1) << 29);
                    r_state <= S_M3;
                end
                S_M3: r_state <= S_M4;
                S_M4: begin
                    r_acc   <= RACC'(mul_p);
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_acc   <= r_acc + (RACC'(mul_p) << 18) + RACC'(2048);
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_drive[r_mod] <= (r_neg[r_mod] ^ r_dmask[r_mod])
                                      ? -signed'(sat_mag) : signed'(sat_mag);
                    if (r_mod == MOD_W'(MODULE_COUNT-1)) begin
                        r_beat  <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_mod   <= r_mod + 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_EMIT: begin
                    if (out_take) begin
                        r_out_valid <= 1'b1;
                        r_out_mod   <= r_beat[MOD_W-1:0];
                        r_out_last  <= last_beat;
                        r_out_dvalid <= 1'b1;
                        if (r_sf && !r_beat[MOD_W]) begin
                            // steer-first beat, drive held
                            r_out_drive  <= '0;
                            r_out_held   <= 1'b1;
                            r_out_steer  <= r_prev[r_beat[MOD_W-1:0]];
                            r_out_svalid <= 1'b1;
                        end else if (r_sf) begin
                            r_out_drive  <= r_drive[r_beat[MOD_W-1:0]];
                            r_out_held   <= 1'b0;
                            r_out_steer  <= '0;
                            r_out_svalid <= 1'b0;
                        end else begin
                            r_out_drive  <= r_drive[r_beat[MOD_W-1:0]];
                            r_out_held   <= 1'b0;
                            r_out_steer  <= r_prev[r_beat[MOD_W-1:0]];
                            r_out_svalid <= 1'b1;
                        end
                        if (last_beat) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_beat <= r_beat + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.module_res    = r_out_mod;
    assign o_res.drive_rate    = r_out_drive;
    assign o_res.drive_valid   = r_out_dvalid;
    assign o_res.drive_held    = r_out_held;
    assign o_res.wheel_heading = r_out_steer;
    assign o_res.steer_valid   = r_out_svalid;
    assign o_res.last_of_run   = r_out_last;

`ifndef SYNTHESIS
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |=> !i_cmd.ready)
        else $error("command accepted while busy");
    a_last_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last_of_run) |-> (o_res.module_res == MOD_W'(MODULE_COUNT-1)))
        else $error("last beat not on final module");
    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.drive_held) |-> (o_res.steer_valid && o_res.drive_rate == 0))
        else $error("held beat carries drive");
    a_steer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.steer_valid) |->
            (o_res.wheel_heading <= 16'sd16384 && o_res.wheel_heading >= -16'sd16384))
        else $error("steer angle beyond a quarter turn");
`endif

endmodule

// ===== hw/rtl/swk_mul.sv =====
module swk_mul import swk_pkg::*; (
    input  logic            i_clk,
    input  logic [MA_W-1:0] i_a,
    input  logic [MB_W-1:0] i_b,
    output logic [MP_W-1:0] o_p
);

    logic [MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MP_W'(i_a) * MP_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/swk_cordic.sv =====
module swk_cordic import swk_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cordic_ctl          i_ctl,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    output logic signed [CW-1:0] o_x,
    output logic [ACC_W-1:0]     o_acc,
    output logic                 o_done
);

    logic signed [CW-1:0] r_x, n_x;
    logic signed [CW-1:0] r_y, n_y;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [STEP_W-1:0]    r_cnt, n_cnt;
    logic signed [CW-1:0] dx, dy;
    logic [ACC_W-1:0]     tab;

    always_comb begin
        dx    = r_y >>> r_cnt;
        dy    = r_x >>> r_cnt;
        tab   = atan_turns(ATAN_IDX_W'(r_cnt));
        n_x   = r_x;
        n_y   = r_y;
        n_acc = r_acc;
        n_cnt = r_cnt;
        if (i_ctl.load) begin
            n_cnt = '0;
            if (i_x < 0) begin
                n_x   = -i_x;
                n_y   = -i_y;
                n_acc = {1'b1, {(ACC_W-1){1'b0}}};
            end else begin
                n_x   = i_x;
                n_y   = i_y;
                n_acc = '0;
            end
        end else if (i_ctl.step) begin
            n_cnt = r_cnt + 1'b1;
            if (r_y > 0) begin
                n_x   = r_x + dx;
                n_y   = r_y - dy;
                n_acc = r_acc + tab;
            end else begin
                n_x   = r_x - dx;
                n_y   = r_y + dy;
                n_acc = r_acc - tab;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
    end

    assign o_x    = r_x;
    assign o_acc  = r_acc;
    assign o_done = (r_cnt == STEP_W'(CORDIC_STEPS - 1));

endmodule
